// ===== hw/rtl/tesec_pkg.sv =====
// Shared types and constants of the top-edge span event counter.
`timescale 1ns / 1ps
package tesec_pkg;

  localparam int ROW_W     = 10;
  localparam int COL_W     = 11;
  localparam int COUNT_W   = 16;
  localparam int WIDTH_W   = 8;
  localparam int THRESH_W  = 10;
  localparam int LOCK_W    = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  localparam cfg_idx_t CFG_SCAN_START     = 2'd0;
  localparam cfg_idx_t CFG_SCAN_WIDTH     = 2'd1;
  localparam cfg_idx_t CFG_SPAN_THRESHOLD = 2'd2;
  localparam cfg_idx_t CFG_LOCK_FRAMES    = 2'd3;

  localparam col_t                 RST_SCAN_START     = 11'd0;
  localparam logic [WIDTH_W-1:0]   RST_SCAN_WIDTH     = 8'd89;
  localparam logic [THRESH_W-1:0]  RST_SPAN_THRESHOLD = 10'd70;
  localparam logic [LOCK_W-1:0]    RST_LOCK_FRAMES    = 8'd20;

  localparam row_t   ROW_ALL_ONES = 10'h3FF;
  localparam count_t COUNT_SAT    = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_PIXEL,
    ST_SWEEP,
    ST_TAIL,
    ST_DSTART,
    ST_DWAIT,
    ST_LOAD
  } tesec_state_t;

endpackage

// ===== hw/rtl/tesec_if.sv =====
// Valid/ready channel interfaces for the pixel and the frame result words.
`timescale 1ns / 1ps
interface tesec_in_if;
  import tesec_pkg::*;

  logic valid;
  logic ready;
  logic pixel;
  row_t pixel_row;
  col_t pixel_col;
  logic frame_end;

  modport source (output valid, pixel, pixel_row, pixel_col, frame_end, input ready);
  modport sink   (input valid, pixel, pixel_row, pixel_col, frame_end, output ready);
endinterface

interface tesec_out_if;
  import tesec_pkg::*;

  logic   valid;
  logic   ready;
  count_t object_count;
  row_t   edge_min;
  row_t   edge_max;
  row_t   edge_avg;
  row_t   edge_span;
  logic   detected;
  logic   hold_active;
  logic   armed;

  modport source (output valid, object_count, edge_min, edge_max, edge_avg, edge_span,
                  detected, hold_active, armed, input ready);
  modport sink   (input valid, object_count, edge_min, edge_max, edge_avg, edge_span,
                  detected, hold_active, armed, output ready);
endinterface

// ===== hw/rtl/tesec_div.sv =====
// Restoring divider, one quotient bit per cycle, for the edge average.
`timescale 1ns / 1ps
module tesec_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_nxt;
  logic             ge;

  // The remainder stays below the divisor, so its low DEN_W bits hold it.
  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== hw/rtl/top_edge_span_event_counter.sv =====
// Top level of the top-edge span event counter.
//
//  Port        Dir    Word                                        Accepted when
//  in_chan     sink   pixel, pixel_row, pixel_col, frame_end      valid && ready
//  out_chan    source object_count, edge_min/max/avg/span, flags  valid && ready
//  cfg_*       in     cfg_index, cfg_wdata                        cfg_we high
//
// Pixels are taken one per cycle except in the clearing pass and while a
// frame is closed. The top edge of each window column lives in a
// one-port-write, one-port-read memory of WINDOW_MAX entries; a pixel word
// reads its column, and in the next cycle the smaller nonzero row is written
// back, with the last write forwarded when the next read hits the same entry.
// A frame-end word closes the frame: the block stops taking words while the
// sweep reads and zeroes every memory entry and the bit-serial divider forms
// the average. The result then sits in an output register so that the next
// frame can start while it waits to be taken. If the previous result is still
// waiting when the next one is ready, the block holds in its last step until
// that word is taken.
// After reset a clearing pass zeroes every memory entry before the first
// pixel is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps
module top_edge_span_event_counter #(
  parameter int WINDOW_MAX = 128,
  parameter int FRAME_ROWS = 1024,
  parameter int FRAME_COLS = 2048
) (
  input  logic                    clk,
  input  logic                    rst_n,
  tesec_in_if.sink                in_chan,
  tesec_out_if.source             out_chan,
  input  logic                    cfg_we,
  input  tesec_pkg::cfg_idx_t     cfg_index,
  input  tesec_pkg::cfg_data_t    cfg_wdata
);
  import tesec_pkg::*;

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = ROW_W + AW;

  // Configuration registers.
  col_t                scan_start_r;
  logic [WIDTH_W-1:0]  scan_width_r;
  logic [THRESH_W-1:0] span_thresh_r;
  logic [LOCK_W-1:0]   lock_frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_start_r  <= RST_SCAN_START;
      scan_width_r  <= RST_SCAN_WIDTH;
      span_thresh_r <= RST_SPAN_THRESHOLD;
      lock_frames_r <= RST_LOCK_FRAMES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCAN_START:     scan_start_r  <= cfg_wdata;
        CFG_SCAN_WIDTH:     scan_width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_SPAN_THRESHOLD: span_thresh_r <= cfg_wdata[THRESH_W-1:0];
        CFG_LOCK_FRAMES:    lock_frames_r <= cfg_wdata[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Window length: a width of zero acts as one column, and the width is
  // clipped to the depth of the edge memory.
  logic [CW-1:0] win_len;
  always_comb begin
    if (scan_width_r == '0) begin
      win_len = CW'(1);
    end else if (32'(scan_width_r) > WINDOW_MAX) begin
      win_len = CW'(WINDOW_MAX);
    end else begin
      win_len = CW'(scan_width_r);
    end
  end

  // Sequencer.
  tesec_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r;
  logic          cnt_last;
  logic          in_ready;
  logic          in_acc;
  logic          sweep_rd;
  logic          clr_wr;
  logic          div_start;
  logic          div_done;
  logic          load;
  logic          out_valid_r;

  assign cnt_last = (cnt_r == AW'(WINDOW_MAX - 1));
  assign in_acc   = in_chan.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    sweep_rd  = 1'b0;
    clr_wr    = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_wr = 1'b1;
        if (cnt_last) state_nxt = ST_PIXEL;
      end
      ST_PIXEL: begin
        in_ready = 1'b1;
        if (in_chan.valid && in_chan.frame_end) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        sweep_rd = 1'b1;
        if (cnt_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_chan.ready) begin
          load      = 1'b1;
          state_nxt = ST_PIXEL;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (clr_wr || sweep_rd) begin
      cnt_r <= cnt_last ? '0 : (cnt_r + AW'(1));
    end
  end

  assign in_chan.ready = in_ready;

  // Pixel filter: only set pixels on a nonzero row inside the frame and the
  // window touch the memory.
  col_t          pix_off;
  logic          pix_hit;
  logic [AW-1:0] pix_addr;

  always_comb begin
    pix_off  = in_chan.pixel_col - scan_start_r;
    pix_addr = pix_off[AW-1:0];
    pix_hit  = in_chan.pixel && (in_chan.pixel_row != '0)
            && (32'(in_chan.pixel_row) < FRAME_ROWS)
            && (32'(in_chan.pixel_col) < FRAME_COLS)
            && (in_chan.pixel_col >= scan_start_r)
            && (32'(pix_off) < 32'(win_len));
  end

  // Edge memory and its read/write ports.
  row_t          mem [WINDOW_MAX];
  row_t          rdata_r;
  logic [AW-1:0] rd_addr_r;
  logic          mem_re;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  row_t          wdata;

  logic          wl_valid_r;
  logic [AW-1:0] wl_addr_r;
  row_t          wl_data_r;
  row_t          rd_val;

  logic          p1_valid_r;
  row_t          p1_row_r;
  logic          p1_upd;
  logic          sv_r;

  assign mem_re = (in_acc && pix_hit) || sweep_rd;
  assign raddr  = sweep_rd ? cnt_r : pix_addr;

  // A write at the same edge as a read is not seen by that read, so the
  // last written word is forwarded when its address matches.
  assign rd_val = (wl_valid_r && (wl_addr_r == rd_addr_r)) ? wl_data_r : rdata_r;
  assign p1_upd = p1_valid_r && ((rd_val == '0) || (p1_row_r < rd_val));

  // The pixel write-back and the sweep's zeroing writes never fall in the same
  // cycle; the sweep zeroes each entry right after reading it.
  always_comb begin
    mem_we = 1'b0;
    waddr  = cnt_r;
    wdata  = '0;
    priority if (p1_upd) begin
      mem_we = 1'b1;
      waddr  = rd_addr_r;
      wdata  = p1_row_r;
    end else if (sv_r) begin
      mem_we = 1'b1;
      waddr  = rd_addr_r;
    end else if (clr_wr) begin
      mem_we = 1'b1;
      waddr  = cnt_r;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) begin
      rdata_r   <= mem[raddr];
      rd_addr_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    wl_addr_r <= waddr;
    wl_data_r <= wdata;
    p1_row_r  <= in_chan.pixel_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_valid_r <= 1'b0;
      p1_valid_r <= 1'b0;
      sv_r       <= 1'b0;
    end else begin
      wl_valid_r <= mem_we;
      p1_valid_r <= in_acc && pix_hit;
      sv_r       <= sweep_rd;
    end
  end

  // Frame reduction over the window entries as the sweep reads them.
  row_t             mn_r;
  row_t             mx_r;
  logic [SUM_W-1:0] sum_r;
  logic             in_win;

  assign in_win = (CW'(rd_addr_r) < win_len);

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.frame_end) begin
      mn_r  <= ROW_ALL_ONES;
      mx_r  <= '0;
      sum_r <= '0;
    end else if (sv_r && in_win) begin
      if (rd_val < mn_r) mn_r <= rd_val;
      if (rd_val > mx_r) mx_r <= rd_val;
      sum_r <= sum_r + SUM_W'(rd_val);
    end
  end

  logic [SUM_W-1:0] quo;

  tesec_div #(
    .NUM_W (SUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (win_len),
    .done  (div_done),
    .quo   (quo)
  );

  // Hold-off lock, arming and counting.
  count_t            object_total_r, object_total_nxt;
  logic              hold_flag_r, hold_flag_nxt;
  logic [LOCK_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic              armed_flag_r, armed_flag_nxt;
  logic              det;
  row_t              span;

  always_comb begin
    span             = mx_r - mn_r;
    object_total_nxt = object_total_r;
    hold_flag_nxt    = hold_flag_r;
    hold_cnt_nxt     = hold_cnt_r;
    armed_flag_nxt   = armed_flag_r;
    det              = 1'b0;
    if ((mn_r != '0) && (mx_r != '0)) begin
      if (hold_flag_r) begin
        if (hold_cnt_r <= LOCK_W'(1)) begin
          hold_cnt_nxt  = '0;
          hold_flag_nxt = 1'b0;
        end else begin
          hold_cnt_nxt = hold_cnt_r - LOCK_W'(1);
        end
      end else if (span > span_thresh_r) begin
        if (!armed_flag_r) begin
          armed_flag_nxt = 1'b1;
        end else if (object_total_r != COUNT_SAT) begin
          object_total_nxt = object_total_r + COUNT_W'(1);
        end
        hold_flag_nxt = 1'b1;
        hold_cnt_nxt  = lock_frames_r;
        det           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_total_r <= '0;
      hold_flag_r    <= 1'b0;
      hold_cnt_r     <= '0;
      armed_flag_r   <= 1'b0;
    end else if (load) begin
      object_total_r <= object_total_nxt;
      hold_flag_r    <= hold_flag_nxt;
      hold_cnt_r     <= hold_cnt_nxt;
      armed_flag_r   <= armed_flag_nxt;
    end
  end

  // Output register.
  count_t o_count_r;
  row_t   o_min_r, o_max_r, o_avg_r, o_span_r;
  logic   o_det_r, o_hold_r, o_armed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_count_r <= object_total_nxt;
      o_min_r   <= mn_r;
      o_max_r   <= mx_r;
      o_avg_r   <= quo[ROW_W-1:0];
      o_span_r  <= span;
      o_det_r   <= det;
      o_hold_r  <= hold_flag_nxt;
      o_armed_r <= armed_flag_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.object_count = o_count_r;
  assign out_chan.edge_min     = o_min_r;
  assign out_chan.edge_max     = o_max_r;
  assign out_chan.edge_avg     = o_avg_r;
  assign out_chan.edge_span    = o_span_r;
  assign out_chan.detected     = o_det_r;
  assign out_chan.hold_active  = o_hold_r;
  assign out_chan.armed        = o_armed_r;

  // Checks.
  a_sweep_data: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> $past(state_r == ST_SWEEP))
    else $error("sweep data without a sweep read");

  a_pixel_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DSTART) |-> !p1_valid_r)
    else $error("pixel write-back still pending at divide start");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_flag_r |-> (hold_cnt_r == '0))
    else $error("hold count left over without a lock");

  a_count_armed: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(object_total_r) |-> armed_flag_r)
    else $error("object count moved before arming");

endmodule
